/* src/random_aligned_descriptor_generator_core_defines.svh */
// assertion macros shared by the descriptor generator modules
`ifndef RANDOM_ALIGNED_DESCRIPTOR_GENERATOR_CORE_DEFINES_SVH
`define RANDOM_ALIGNED_DESCRIPTOR_GENERATOR_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define RADG_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define RADG_ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RADG_ASSERT(label, clk, rst, prop, msg)
`define RADG_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

/* src/radg_pkg.sv */
`timescale 1ns / 1ps

package radg_pkg;

   // field and register widths
   localparam int BlobW  = 41;
   localparam int SeedW  = 64;
   localparam int DescW  = 7;
   localparam int AlignW = 21;
   localparam int PayW   = 16;
   localparam int SeqW   = 64;
   localparam int OffW   = 40;
   localparam int LenW   = 16;
   localparam int DataW  = 64;

   localparam int MaxDesc    = 64;
   localparam int MaxPayload = 64000;
   localparam int IdxW       = $clog2(MaxDesc);

   localparam int RspDataW = 128;

   // divider works through the full generator word, one bit per cycle
   localparam int DivSteps = DataW;
   localparam int DivCntW  = $clog2(DivSteps);

   localparam logic [DataW-1:0] SeqMult = 64'h0000_0000_0000_9e37;
   localparam logic [DataW-1:0] MixMult = 64'd2685821657736338717;

   localparam logic [DescW-1:0]  DefaultDesc  = 7'd16;
   localparam logic [AlignW-1:0] DefaultAlign = 21'd64;

   // reset values of the csr registers
   localparam logic [BlobW-1:0]  BlobReset  = 41'd1073741824;
   localparam logic [SeedW-1:0]  SeedReset  = 64'd305419896;
   localparam logic [DescW-1:0]  DescReset  = 7'd16;
   localparam logic [AlignW-1:0] AlignReset = 21'd64;

   // register indexes
   localparam logic [1:0] RegBlob  = 2'd0;
   localparam logic [1:0] RegSeed  = 2'd1;
   localparam logic [1:0] RegDesc  = 2'd2;
   localparam logic [1:0] RegAlign = 2'd3;

   // partial product select of the shared 32x32 multiplier
   localparam logic [1:0] MulLoLo = 2'd0;
   localparam logic [1:0] MulLoHi = 2'd1;
   localparam logic [1:0] MulHiLo = 2'd2;

   typedef struct packed {
      logic [BlobW-1:0]  blob;
      logic [SeedW-1:0]  seed;
      logic [DescW-1:0]  desc;
      logic [AlignW-1:0] align;
   } cfg_type;

   typedef struct packed {
      logic       load_item;
      logic       div_pay;
      logic       latch_div;
      logic       mul_en;
      logic [1:0] mul_phase;
      logic       mul_seed;
      logic       seed_add;
      logic       mix;
      logic       mul_load;
      logic       emit;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
      logic quot_zero;
      logic out_free;
      logic last_desc;
   } stat_type;

   function automatic logic [PayW-1:0] pay_clamp(input logic [PayW-1:0] pay);
      logic [PayW-1:0] lim;
      lim = PayW'(MaxPayload);
      return (pay > lim) ? lim : pay;
   endfunction

   function automatic logic [DescW-1:0] desc_eff(input logic [DescW-1:0] d);
      logic [DescW-1:0] lim;
      lim = DescW'(MaxDesc);
      if (d == '0) begin
         return DefaultDesc;
      end
      return (d > lim) ? lim : d;
   endfunction

   function automatic logic [AlignW-1:0] align_eff(input logic [AlignW-1:0] al);
      return (al == '0) ? DefaultAlign : al;
   endfunction

   function automatic logic [DataW-1:0] xorshift(input logic [DataW-1:0] x);
      logic [DataW-1:0] t;
      t = x ^ (x >> 12);
      t = t ^ (t << 25);
      t = t ^ (t >> 27);
      return t;
   endfunction

endpackage

/* src/radg_divider.sv */
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle
module radg_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [radg_pkg::DataW-1:0]  dividend,
   input  logic [radg_pkg::BlobW-1:0]  divisor,
   output logic                        busy,
   output logic [radg_pkg::DataW-1:0]  quot,
   output logic [radg_pkg::BlobW-1:0]  rem
);

   localparam int DW = radg_pkg::DataW;
   localparam int RW = radg_pkg::BlobW;
   localparam int CW = radg_pkg::DivCntW;

   logic          busy_ff, busy_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] quot_ff, quot_in;
   logic [RW-1:0] rem_ff, rem_in;
   logic [RW-1:0] dvs_ff, dvs_in;
   logic [RW:0]   trial;
   logic [RW:0]   diff;
   logic          fits;

   assign trial = {rem_ff, quot_ff[DW-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(radg_pkg::DivSteps - 1);
         quot_in = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         quot_in = {quot_ff[DW-2:0], fits};
         rem_in  = fits ? diff[RW-1:0] : trial[RW-1:0];
         cnt_in  = cnt_ff - CW'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   assign busy = busy_ff;
   assign quot = quot_ff;
   assign rem  = rem_ff;

endmodule

/* src/radg_datapath.sv */
`timescale 1ns / 1ps
`include "random_aligned_descriptor_generator_core_defines.svh"

module radg_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  radg_pkg::cfg_type              cfg,
   input  radg_pkg::cmd_type              cmd,
   output radg_pkg::stat_type             stat,
   input  logic [radg_pkg::PayW-1:0]      pay_bytes,
   input  logic                           rsp_tready,
   output logic                           rsp_tvalid,
   output logic [radg_pkg::RspDataW-1:0]  rsp_tdata,
   output logic                           rsp_tlast
);

   localparam int DW = radg_pkg::DataW;
   localparam int BW = radg_pkg::BlobW;
   localparam int LW = radg_pkg::LenW;
   localparam int IW = radg_pkg::IdxW;
   localparam int QW = radg_pkg::DescW;
   localparam int AW = radg_pkg::AlignW;
   localparam int OW = radg_pkg::OffW;
   localparam int PadW = radg_pkg::RspDataW - radg_pkg::SeqW - IW - OW - LW;

   logic [DW-1:0] seq_counter_ff, seq_counter_in;
   logic [DW-1:0] seq_ff, seq_in;
   logic [DW-1:0] x_ff, x_in;
   logic [DW-1:0] acc_ff, acc_in;
   logic [LW-1:0] base_ff, base_in;
   logic [IW-1:0] extra_ff, extra_in;
   logic [IW-1:0] idx_ff, idx_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0] rsp_seq_ff;
   logic [IW-1:0] rsp_idx_ff;
   logic [OW-1:0] rsp_off_ff;
   logic [LW-1:0] rsp_len_ff;
   logic          rsp_last_ff;

   logic [QW-1:0] d_eff;
   logic [AW-1:0] al_eff;
   logic [BW-1:0] modv;
   logic [BW-1:0] mask;

   logic          div_start;
   logic [DW-1:0] div_dividend;
   logic [BW-1:0] div_divisor;
   logic          div_busy;
   logic [DW-1:0] div_quot;
   logic [BW-1:0] div_rem;

   logic [DW-1:0] mul_b;
   logic [31:0]   opa, opb;
   logic [DW-1:0] prod;

   logic [LW-1:0] len_raw;
   logic [LW-1:0] len_c;
   logic [BW-1:0] off_raw;
   logic [BW-1:0] off_fit;
   logic [BW-1:0] off_sel;
   logic          over;
   logic          last_desc;
   logic          out_free;

   assign d_eff  = radg_pkg::desc_eff(cfg.desc);
   assign al_eff = radg_pkg::align_eff(cfg.align);
   assign modv   = (cfg.blob == '0) ? BW'(1) : cfg.blob;
   assign mask   = ~({{(BW-AW){1'b0}}, al_eff} - BW'(1));

   // shared divider: payload split first, then one modulo per descriptor
   assign div_start    = cmd.div_pay | cmd.mul_load;
   assign div_dividend = cmd.div_pay
                         ? {{(DW-radg_pkg::PayW){1'b0}}, radg_pkg::pay_clamp(pay_bytes)}
                         : acc_ff;
   assign div_divisor  = cmd.div_pay ? {{(BW-QW){1'b0}}, d_eff} : modv;

   radg_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quot     (div_quot),
      .rem      (div_rem)
   );

   // 64x64 low product from three 32x32 partial products
   assign mul_b = cmd.mul_seed ? radg_pkg::SeqMult : radg_pkg::MixMult;

   always_comb begin
      case (cmd.mul_phase)
         radg_pkg::MulLoHi: begin
            opa = x_ff[31:0];
            opb = mul_b[63:32];
         end
         radg_pkg::MulHiLo: begin
            opa = x_ff[63:32];
            opb = mul_b[31:0];
         end
         default: begin
            opa = x_ff[31:0];
            opb = mul_b[31:0];
         end
      endcase
   end

   assign prod = {32'd0, opa} * {32'd0, opb};

   always_comb begin
      acc_in = acc_ff;
      if (cmd.mul_en) begin
         if (cmd.mul_phase == radg_pkg::MulLoLo) begin
            acc_in = prod;
         end else begin
            acc_in = acc_ff + {prod[31:0], 32'd0};
         end
      end
   end

   always_comb begin
      x_in = x_ff;
      if (cmd.load_item) begin
         x_in = seq_counter_ff;
      end else if (cmd.seed_add) begin
         x_in = acc_ff + cfg.seed;
      end else if (cmd.mix) begin
         x_in = radg_pkg::xorshift(x_ff);
      end else if (cmd.mul_load) begin
         x_in = acc_ff;
      end
   end

   always_comb begin
      seq_counter_in = seq_counter_ff;
      seq_in         = seq_ff;
      base_in        = base_ff;
      extra_in       = extra_ff;
      idx_in         = idx_ff;
      if (cmd.load_item) begin
         seq_counter_in = seq_counter_ff + DW'(1);
         seq_in         = seq_counter_ff;
         idx_in         = '0;
      end
      if (cmd.latch_div) begin
         base_in  = div_quot[LW-1:0];
         extra_in = div_rem[IW-1:0];
      end
      if (cmd.emit) begin
         idx_in = idx_ff + IW'(1);
      end
   end

   // offset placement and clamp into the region
   assign last_desc = {1'b0, idx_ff} == (d_eff - QW'(1));
   assign len_raw   = base_ff + (last_desc ? {{(LW-IW){1'b0}}, extra_ff} : '0);
   assign len_c     = ({{(BW-LW){1'b0}}, len_raw} > cfg.blob) ? cfg.blob[LW-1:0] : len_raw;
   assign off_raw   = div_rem & mask;
   assign over      = ({1'b0, off_raw} + {{(BW+1-LW){1'b0}}, len_raw}) > {1'b0, cfg.blob};
   assign off_fit   = (cfg.blob - {{(BW-LW){1'b0}}, len_c}) & mask;
   assign off_sel   = over ? off_fit : off_raw;

   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign rsp_valid_in = cmd.emit ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_counter_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         seq_counter_ff <= seq_counter_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      seq_ff   <= seq_in;
      x_ff     <= x_in;
      acc_ff   <= acc_in;
      base_ff  <= base_in;
      extra_ff <= extra_in;
      idx_ff   <= idx_in;
      if (cmd.emit) begin
         rsp_seq_ff  <= seq_ff;
         rsp_idx_ff  <= idx_ff;
         rsp_off_ff  <= off_sel[OW-1:0];
         rsp_len_ff  <= len_c;
         rsp_last_ff <= last_desc;
      end
   end

   assign stat.div_busy  = div_busy;
   assign stat.quot_zero = div_quot == '0;
   assign stat.out_free  = out_free;
   assign stat.last_desc = last_desc;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{PadW{1'b0}}, rsp_len_ff, rsp_off_ff, rsp_idx_ff, rsp_seq_ff};

   `RADG_ASSERT(a_seq_advance, clock, reset,
      cmd.load_item |=> seq_counter_ff == $past(seq_counter_ff) + 64'd1, "sequence did not advance")
   `RADG_ASSERT(a_div_idle_start, clock, reset,
      div_start |-> !div_busy, "divider restarted while busy")
   `RADG_ASSERT_NORST(a_rsp_clear_after_reset, clock,
      reset |=> !rsp_valid_ff, "result beat valid right after reset")

endmodule

/* src/radg_ctrl.sv */
`timescale 1ns / 1ps
`include "random_aligned_descriptor_generator_core_defines.svh"

module radg_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output radg_pkg::cmd_type  cmd,
   input  radg_pkg::stat_type stat
);

   localparam logic [3:0] StIdle    = 4'd0;
   localparam logic [3:0] StDivWait = 4'd1;
   localparam logic [3:0] StSeed0   = 4'd2;
   localparam logic [3:0] StSeed1   = 4'd3;
   localparam logic [3:0] StSeed2   = 4'd4;
   localparam logic [3:0] StSeedAdd = 4'd5;
   localparam logic [3:0] StMix     = 4'd6;
   localparam logic [3:0] StMul0    = 4'd7;
   localparam logic [3:0] StMul1    = 4'd8;
   localparam logic [3:0] StMul2    = 4'd9;
   localparam logic [3:0] StMulLoad = 4'd10;
   localparam logic [3:0] StModWait = 4'd11;
   localparam logic [3:0] StEmit    = 4'd12;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         StIdle: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_item = 1'b1;
               cmd.div_pay   = 1'b1;
               state_in      = StDivWait;
            end
         end
         StDivWait: begin
            if (!stat.div_busy) begin
               cmd.latch_div = 1'b1;
               state_in      = stat.quot_zero ? StIdle : StSeed0;
            end
         end
         StSeed0: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_seed  = 1'b1;
            cmd.mul_phase = radg_pkg::MulLoLo;
            state_in      = StSeed1;
         end
         StSeed1: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_seed  = 1'b1;
            cmd.mul_phase = radg_pkg::MulLoHi;
            state_in      = StSeed2;
         end
         StSeed2: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_seed  = 1'b1;
            cmd.mul_phase = radg_pkg::MulHiLo;
            state_in      = StSeedAdd;
         end
         StSeedAdd: begin
            cmd.seed_add = 1'b1;
            state_in     = StMix;
         end
         StMix: begin
            cmd.mix  = 1'b1;
            state_in = StMul0;
         end
         StMul0: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_phase = radg_pkg::MulLoLo;
            state_in      = StMul1;
         end
         StMul1: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_phase = radg_pkg::MulLoHi;
            state_in      = StMul2;
         end
         StMul2: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_phase = radg_pkg::MulHiLo;
            state_in      = StMulLoad;
         end
         StMulLoad: begin
            cmd.mul_load = 1'b1;
            state_in     = StModWait;
         end
         StModWait: begin
            if (!stat.div_busy) begin
               state_in = StEmit;
            end
         end
         StEmit: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = stat.last_desc ? StIdle : StMix;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
      end else begin
         state_ff <= state_in;
      end
   end

   `RADG_ASSERT(a_busy_after_accept, clock, reset,
      req_tvalid && req_tready |=> !req_tready, "still ready right after taking a beat")
   `RADG_ASSERT(a_no_accept_while_dividing, clock, reset,
      stat.div_busy |-> !req_tready, "ready while the divider runs")

endmodule

/* src/random_aligned_descriptor_generator_core.sv */
`timescale 1ns / 1ps

// random aligned descriptor generator
// req channel: one beat per datagram, carrying its payload length in bytes
// rsp channel: one beat per descriptor (sequence, index, offset, length), tlast
//    marks the final descriptor of the datagram; a datagram whose payload is
//    shorter than the descriptor count yields no beats but still takes a sequence
// csr port: region size, generator seed, descriptor count, alignment at 8*i
// order of work: the req beat is taken, the payload is split, the generator is
//    seeded, and then each descriptor is mixed, multiplied, reduced modulo the
//    region and emitted, while rsp_tready keeps up; the next req beat is taken
//    after the last descriptor, or straight after the split when it yields nothing
// the per-descriptor time is set by the shared bit-serial divider (one full run
//    per modulo) plus the 32x32 multiplier used once per partial product
// req_tready is high only while the sequencer is idle; one datagram at a time
// the result register lets the engine finish the next descriptor while a beat
//    waits; with rsp_tready low the engine holds at the emit step
// reset (synchronous) clears the sequence counter, the result valid and the
//    sequencer, and loads the csr reset values
module random_aligned_descriptor_generator_core (
   input  logic                            clock,
   input  logic                            reset,
   // request side
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [radg_pkg::PayW-1:0]       req_tdata,   // pay_bytes[15:0]
   // response side
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // sequence_res[63:0], desc_index[69:64], offset[109:70], length[125:110], zero pad
   output logic [radg_pkg::RspDataW-1:0]   rsp_tdata,
   output logic                            rsp_tlast,   // is_last
   // csr port
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [4:0]                      csr_paddr,
   input  logic [63:0]                     csr_pwdata,
   output logic [63:0]                     csr_prdata,
   output logic                            csr_pready
);

   localparam int BW = radg_pkg::BlobW;
   localparam int SW = radg_pkg::SeedW;
   localparam int QW = radg_pkg::DescW;
   localparam int AW = radg_pkg::AlignW;

   logic [BW-1:0] blob_ff, blob_in;
   logic [SW-1:0] seed_ff, seed_in;
   logic [QW-1:0] desc_ff, desc_in;
   logic [AW-1:0] align_ff, align_in;

   logic [1:0]          reg_idx;
   logic                csr_wr;
   radg_pkg::cfg_type   cfg;
   radg_pkg::cmd_type   cmd;
   radg_pkg::stat_type  stat;

   // registers sit on 8 byte steps, low address bits ignored
   assign reg_idx    = csr_paddr[4:3];
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      blob_in  = blob_ff;
      seed_in  = seed_ff;
      desc_in  = desc_ff;
      align_in = align_ff;
      if (csr_wr) begin
         unique case (reg_idx)
            radg_pkg::RegBlob:  blob_in  = csr_pwdata[BW-1:0];
            radg_pkg::RegSeed:  seed_in  = csr_pwdata[SW-1:0];
            radg_pkg::RegDesc:  desc_in  = csr_pwdata[QW-1:0];
            radg_pkg::RegAlign: align_in = csr_pwdata[AW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blob_ff  <= radg_pkg::BlobReset;
         seed_ff  <= radg_pkg::SeedReset;
         desc_ff  <= radg_pkg::DescReset;
         align_ff <= radg_pkg::AlignReset;
      end else begin
         blob_ff  <= blob_in;
         seed_ff  <= seed_in;
         desc_ff  <= desc_in;
         align_ff <= align_in;
      end
   end

   // register read back
   always_comb begin
      unique case (reg_idx)
         radg_pkg::RegBlob:  csr_prdata = {{(64-BW){1'b0}}, blob_ff};
         radg_pkg::RegSeed:  csr_prdata = seed_ff;
         radg_pkg::RegDesc:  csr_prdata = {{(64-QW){1'b0}}, desc_ff};
         radg_pkg::RegAlign: csr_prdata = {{(64-AW){1'b0}}, align_ff};
         default:            csr_prdata = '0;
      endcase
   end

   assign cfg.blob  = blob_ff;
   assign cfg.seed  = seed_ff;
   assign cfg.desc  = desc_ff;
   assign cfg.align = align_ff;

   // sequencer: walks split, seeding, then mix / multiply / modulo / emit per descriptor
   radg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   // datapath: generator state, shared multiplier and divider, result register
   radg_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .cmd         (cmd),
      .stat        (stat),
      .pay_bytes   (req_tdata),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

/* sim/tb_random_aligned_descriptor_generator_core.sv */
`timescale 1ns / 1ps

module tb_random_aligned_descriptor_generator_core;

   // quiet time after the last descriptor, covers a datagram that emits nothing
   localparam int SettleCycles  = 400;
   // cycles with no beat and no csr write before the run is declared hung
   localparam int WatchdogLimit = 20000;
   localparam int RandomPhases  = 8;
   localparam int PhaseBeats    = 56;

   // field positions in rsp_tdata
   localparam int IdxLsb = radg_pkg::SeqW;
   localparam int OffLsb = IdxLsb + radg_pkg::IdxW;
   localparam int LenLsb = OffLsb + radg_pkg::OffW;

   typedef struct packed {
      logic [radg_pkg::SeqW-1:0] seq;
      logic [radg_pkg::IdxW-1:0] idx;
      logic [radg_pkg::OffW-1:0] off;
      logic [radg_pkg::LenW-1:0] len;
      logic                      last;
   } descriptor_type;

   logic                          clock       = 1'b0;
   logic                          reset       = 1'b1;
   logic                          req_tvalid  = 1'b0;
   logic                          req_tready;
   logic [radg_pkg::PayW-1:0]     req_tdata   = '0;   // pay_bytes[15:0]
   logic                          rsp_tvalid;
   logic                          rsp_tready  = 1'b0;
   // sequence_res[63:0], desc_index[69:64], offset[109:70], length[125:110]
   logic [radg_pkg::RspDataW-1:0] rsp_tdata;
   logic                          rsp_tlast;          // is_last
   logic                          csr_psel    = 1'b0;
   logic                          csr_penable = 1'b0;
   logic                          csr_pwrite  = 1'b0;
   logic [4:0]                    csr_paddr   = '0;
   logic [63:0]                   csr_pwdata  = '0;
   logic [63:0]                   csr_prdata;
   logic                          csr_pready;

   // our copy of the csr registers and of the datagram sequence counter
   logic [radg_pkg::BlobW-1:0]  cfg_blob  = radg_pkg::BlobReset;
   logic [radg_pkg::SeedW-1:0]  cfg_seed  = radg_pkg::SeedReset;
   logic [radg_pkg::DescW-1:0]  cfg_desc  = radg_pkg::DescReset;
   logic [radg_pkg::AlignW-1:0] cfg_align = radg_pkg::AlignReset;
   logic [radg_pkg::SeqW-1:0]   datagram_seq = '0;

   // descriptors predicted but not yet seen on the rsp side, oldest first
   descriptor_type pending_descs[$];
   int unsigned fail_count   = 0;
   int unsigned quiet_cycles = 0;
   // random idling on both sides; cleared for a calm stretch
   bit          idle_en      = 1'b1;

   random_aligned_descriptor_generator_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // the receiver stalls about one cycle in four while idling is on
   always @(posedge clock) begin
      rsp_tready <= idle_en ? ($urandom_range(99) >= 25) : 1'b1;
   end

   function automatic void log_mismatch(input string what);
      fail_count++;
      if (fail_count <= 10) begin
         $display("%0t: %s", $time, what);
      end
   endfunction

   // works out every descriptor of one accepted datagram and queues them
   function automatic void predict_descriptors(input logic [radg_pkg::PayW-1:0] pay_in);
      logic [63:0] pay, parts, align, keep_mask, region, modulus, seq;
      logic [63:0] base, extra, state, len, off, i;
      descriptor_type d;
      pay       = 64'(pay_in);
      parts     = (cfg_desc == '0) ? 64'(radg_pkg::DefaultDesc) : 64'(cfg_desc);
      align     = (cfg_align == '0) ? 64'(radg_pkg::DefaultAlign) : 64'(cfg_align);
      keep_mask = ~(align - 64'd1);
      region    = 64'(cfg_blob);
      modulus   = (region == 64'd0) ? 64'd1 : region;
      seq       = datagram_seq;
      if (pay > 64'(radg_pkg::MaxPayload)) pay = 64'(radg_pkg::MaxPayload);
      if (parts > 64'(radg_pkg::MaxDesc)) parts = 64'(radg_pkg::MaxDesc);
      // the sequence advances even when the datagram yields nothing
      datagram_seq = datagram_seq + 64'd1;
      base  = pay / parts;
      extra = pay % parts;
      if (base == 64'd0) return;
      state = cfg_seed + seq * radg_pkg::SeqMult;
      for (i = 0; i < parts; i++) begin
         // last part takes the remainder
         len   = base + ((i == parts - 64'd1) ? extra : 64'd0);
         state = state ^ (state >> 12);
         state = state ^ (state << 25);
         state = state ^ (state >> 27);
         state = state * radg_pkg::MixMult;
         off   = (state % modulus) & keep_mask;
         // pull the part back inside the region, shrinking it if the region is smaller
         if (off + len > region) begin
            if (len > region) len = region;
            off = (region - len) & keep_mask;
         end
         d.seq  = seq;
         d.idx  = i[radg_pkg::IdxW-1:0];
         d.off  = off[radg_pkg::OffW-1:0];
         d.len  = len[radg_pkg::LenW-1:0];
         d.last = (i == parts - 64'd1);
         pending_descs.push_back(d);
      end
   endfunction

   // every rsp beat is held against the oldest predicted descriptor
   always @(posedge clock) begin : check_rsp
      descriptor_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.seq  = rsp_tdata[radg_pkg::SeqW-1:0];
         got.idx  = rsp_tdata[IdxLsb +: radg_pkg::IdxW];
         got.off  = rsp_tdata[OffLsb +: radg_pkg::OffW];
         got.len  = rsp_tdata[LenLsb +: radg_pkg::LenW];
         got.last = rsp_tlast;
         if (pending_descs.size() == 0) begin
            log_mismatch($sformatf("beat with nothing expected: seq %0h idx %0d off %0h len %0d",
                                   got.seq, got.idx, got.off, got.len));
         end else begin
            want = pending_descs.pop_front();
            if (got.seq != want.seq)
               log_mismatch($sformatf("sequence exp %0h got %0h", want.seq, got.seq));
            if (got.idx != want.idx)
               log_mismatch($sformatf("seq %0h index exp %0d got %0d",
                                      want.seq, want.idx, got.idx));
            if (got.off != want.off)
               log_mismatch($sformatf("seq %0h idx %0d offset exp %0h got %0h",
                                      want.seq, want.idx, want.off, got.off));
            if (got.len != want.len)
               log_mismatch($sformatf("seq %0h idx %0d length exp %0d got %0d",
                                      want.seq, want.idx, want.len, got.len));
            if (got.last != want.last)
               log_mismatch($sformatf("seq %0h idx %0d last exp %0b got %0b",
                                      want.seq, want.idx, want.last, got.last));
         end
      end
   end

   // hang detection: any beat or csr write restarts the count
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable && csr_pwrite && csr_pready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
         $display("random_aligned_descriptor_generator_core: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // one datagram on the req side, with an occasional gap before it
   task automatic send_payload(input logic [radg_pkg::PayW-1:0] pay);
      if (idle_en && $urandom_range(99) < 25) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pay;
      do @(posedge clock); while (!req_tready);
      predict_descriptors(pay);
   endtask

   // stop sending and wait for every predicted descriptor
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_descs.size() != 0);
   endtask

   // setup phase, access phase, then an idle gap so writes never touch back to back
   task automatic write_csr(input logic [1:0] idx, input logic [63:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         radg_pkg::RegBlob:  cfg_blob  = value[radg_pkg::BlobW-1:0];
         radg_pkg::RegSeed:  cfg_seed  = value[radg_pkg::SeedW-1:0];
         radg_pkg::RegDesc:  cfg_desc  = value[radg_pkg::DescW-1:0];
         radg_pkg::RegAlign: cfg_align = value[radg_pkg::AlignW-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // registers change only once the block has gone quiet
   task automatic apply_config(input logic [63:0] blob, input logic [63:0] seed,
                               input logic [63:0] desc, input logic [63:0] align);
      wait_drained();
      repeat (SettleCycles) @(posedge clock);
      write_csr(radg_pkg::RegBlob, blob);
      write_csr(radg_pkg::RegSeed, seed);
      write_csr(radg_pkg::RegDesc, desc);
      write_csr(radg_pkg::RegAlign, align);
   endtask

   // reset settings: sixteen parts, split boundary, payload clamp, all payload bits
   task automatic test_reset_defaults();
      send_payload(16'd0);
      send_payload(16'd15);
      send_payload(16'd16);
      send_payload(16'd17);
      send_payload(16'd64000);
      send_payload(16'hffff);
      send_payload(16'h5555);
      send_payload(16'haaaa);
   endtask

   // one part, the full sixty-four, a count above the cap and zero meaning sixteen
   task automatic test_descriptor_count();
      apply_config(64'(radg_pkg::BlobReset), 64'(radg_pkg::SeedReset), 64'd1,
                   64'(radg_pkg::AlignReset));
      send_payload(16'd1);
      send_payload(16'd64001);
      apply_config(64'(radg_pkg::BlobReset), 64'(radg_pkg::SeedReset), 64'd64,
                   64'(radg_pkg::AlignReset));
      send_payload(16'd63);
      send_payload(16'd64);
      send_payload(16'd4095);
      apply_config(64'(radg_pkg::BlobReset), 64'(radg_pkg::SeedReset), 64'd127,
                   64'(radg_pkg::AlignReset));
      send_payload(16'd200);
      apply_config(64'(radg_pkg::BlobReset), 64'(radg_pkg::SeedReset), 64'd0,
                   64'(radg_pkg::AlignReset));
      send_payload(16'd31);
   endtask

   // byte alignment, odd alignment, largest power, all ones and zero meaning sixty-four
   task automatic test_alignment();
      apply_config(64'(radg_pkg::BlobReset), 64'h0123_4567_89ab_cdef, 64'd4, 64'd1);
      send_payload(16'd1000);
      apply_config(64'(radg_pkg::BlobReset), 64'h0123_4567_89ab_cdef, 64'd4, 64'd3);
      send_payload(16'd1000);
      apply_config(64'(radg_pkg::BlobReset), 64'h0123_4567_89ab_cdef, 64'd4, 64'd1048576);
      send_payload(16'd1000);
      apply_config(64'(radg_pkg::BlobReset), 64'h0123_4567_89ab_cdef, 64'd4, 64'h1f_ffff);
      send_payload(16'd1000);
      apply_config(64'(radg_pkg::BlobReset), 64'h0123_4567_89ab_cdef, 64'd4, 64'd0);
      send_payload(16'd1000);
   endtask

   // empty region, one byte region, parts larger than the region, and wide regions
   task automatic test_region_bounds();
      apply_config(64'd0, 64'd0, 64'd4, 64'd64);
      send_payload(16'd100);
      apply_config(64'd1, 64'hffff_ffff_ffff_ffff, 64'd4, 64'd64);
      send_payload(16'd100);
      apply_config(64'd100, 64'h5a5a_a5a5_0f0f_f0f0, 64'd4, 64'd16);
      send_payload(16'd1000);
      apply_config(64'd300, 64'h5a5a_a5a5_0f0f_f0f0, 64'd4, 64'd16);
      send_payload(16'd1000);
      apply_config(64'd1 << 40, 64'hdead_beef_0bad_f00d, 64'd4, 64'd64);
      send_payload(16'd500);
      // region above 2^40: offsets come back cut to 40 bits
      apply_config((64'd1 << 41) - 64'd1, 64'hffff_ffff_ffff_ffff, 64'd4, 64'd1);
      send_payload(16'd500);
   endtask

   // random settings per phase; first phase runs without idling, a middle one drains halfway
   task automatic test_random_traffic();
      int          p, n;
      int unsigned parts;
      logic [63:0] blob, seed, desc, align;
      int unsigned pay;
      for (p = 0; p < RandomPhases; p++) begin
         case ($urandom_range(5))
            0: blob = 64'($urandom_range(1, 70000));
            1: blob = {24'd0, 8'($urandom_range(255)), 32'($urandom)};
            2: blob = 64'd1 << 40;
            3: blob = 64'($urandom_range(64, 4096));
            default: blob = 64'(radg_pkg::BlobReset);
         endcase
         if (blob == 64'd0) blob = 64'd1;
         seed = {32'($urandom), 32'($urandom)};
         case ($urandom_range(7))
            5: desc = 64'd0;
            6: desc = 64'($urandom_range(9, 12));
            7: desc = 64'd1;
            default: desc = 64'($urandom_range(1, 8));
         endcase
         if ($urandom_range(3) == 0) align = 64'($urandom_range(1, 2000));
         else align = 64'd1 << $urandom_range(20);
         apply_config(blob, seed, desc, align);
         parts   = (desc == 64'd0) ? 16 : int'(desc);
         idle_en = (p != 0);
         for (n = 0; n < PhaseBeats; n++) begin
            // sender holds off until everything predicted so far has come back
            if (p == 3 && n == PhaseBeats / 2) wait_drained();
            case ($urandom_range(9))
               0: pay = $urandom_range(0, 2 * parts);
               1: pay = $urandom_range(0, 65535);
               2: pay = $urandom_range(63990, 65535);
               default: pay = $urandom_range(parts, 4000);
            endcase
            send_payload(16'(pay));
         end
      end
      idle_en = 1'b1;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_descriptor_count();
      test_alignment();
      test_region_bounds();
      test_random_traffic();
      wait_drained();
      // leave room for stray beats after the last expected one
      repeat (SettleCycles) @(posedge clock);
      if (fail_count == 0 && pending_descs.size() == 0) begin
         $display("random_aligned_descriptor_generator_core: match");
      end else begin
         $display("random_aligned_descriptor_generator_core: mismatch");
      end
      $finish;
   end

endmodule
